@@ rtl/mwr_pkg.sv @@
// Shared types and constants of the uniform weight reduction block.
// No dependencies; used by mwr_bf and max_uniform_weight_reduction.
package mwr_pkg;

    // Distances are kept as signed 32-bit values; the maximum means unreached.
    localparam int DIST_W = 32;
    localparam logic [DIST_W-1:0] DIST_INF = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_ONE = 32'h0000_0001;

    // Widened candidate distance and its saturation limits.
    localparam int CAND_W = 34;
    localparam logic signed [CAND_W-1:0] CAND_LO = -34'sd2147483648;
    localparam logic signed [CAND_W-1:0] CAND_HI = 34'sd2147483646;

    // Sequencer of one negative-cycle test.
    typedef enum logic [3:0] {
        BF_IDLE,
        BF_INIT,
        BF_ESTART,
        BF_EREAD,
        BF_EWAIT,
        BF_DS,
        BF_DD,
        BF_EEND,
        BF_VREAD,
        BF_VWAIT,
        BF_RNDEND,
        BF_DONE
    } t_bf_state;

    // Top-level control of loading and binary search.
    typedef enum logic [1:0] {
        T_IDLE,
        T_BOUNDS,
        T_DECIDE,
        T_WAIT
    } t_top_state;

    // Result of one test, handed back to the search control.
    typedef struct packed {
        logic done;
        logic no_cycle;
    } t_bf_status;

endpackage

@@ rtl/mwr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/mwr_bf.sv @@
// Bellman-Ford negative-cycle test for one reduction value over the edge store.
// Depends on mwr_pkg and mwr_ram (distance memory).
module mwr_bf #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16,
    parameter int CW  = WEIGHT_BITS + 1,
    parameter int VW  = $clog2(MAX_VERTICES + 1),
    parameter int ECW = $clog2(MAX_EDGES + 1),
    parameter int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    parameter int EW  = 14 + WEIGHT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CW-1:0]       i_c,
    input  logic [VW-1:0]       i_n,
    input  logic [ECW-1:0]      i_edge_count,
    output logic [EAW-1:0]      o_edge_raddr,
    input  logic [EW-1:0]       i_edge_rdata,
    output mwr_pkg::t_bf_status o_status
);

    mwr_pkg::t_bf_state r_state, n_state;

    logic [EAW-1:0]         r_eidx;
    logic [VW-1:0]          r_vidx;
    logic [VW-1:0]          r_round;
    logic                   r_check;
    logic                   r_ok;
    logic [CW-1:0]          r_c;
    logic [VW-1:0]          r_dst;
    logic [WEIGHT_BITS-1:0] r_wt;
    logic signed [mwr_pkg::CAND_W-1:0] r_cand;
    logic                   r_inf;

    // Distance memory port signals.
    logic                       dist_we;
    logic [VW-1:0]              dist_waddr;
    logic [mwr_pkg::DIST_W-1:0] dist_wdata;
    logic [VW-1:0]              dist_raddr;
    logic [mwr_pkg::DIST_W-1:0] dist_rdata;

    // Fields of the edge being read.
    logic [6:0]             e_src;
    logic [6:0]             e_dst;
    logic [WEIGHT_BITS-1:0] e_wt;
    logic                   e_in_range;
    logic                   last_edge;
    logic signed [mwr_pkg::CAND_W-1:0] cand_now;
    logic signed [mwr_pkg::CAND_W-1:0] dd_x;
    logic                   improves;
    logic [mwr_pkg::DIST_W-1:0] cand_sat;

    assign e_src = i_edge_rdata[EW-1 -: 7];
    assign e_dst = i_edge_rdata[EW-8 -: 7];
    assign e_wt  = i_edge_rdata[WEIGHT_BITS-1:0];

    assign e_in_range = (e_src != 7'd0) && (32'(e_src) <= 32'(i_n)) &&
                        (e_dst != 7'd0) && (32'(e_dst) <= 32'(i_n));
    assign last_edge  = (32'(r_eidx) + 32'd1) == 32'(i_edge_count);

    // Candidate distance from the source entry as it arrives from memory.
    assign cand_now = mwr_pkg::CAND_W'($signed(dist_rdata))
                    + $signed(mwr_pkg::CAND_W'(r_wt))
                    - $signed(mwr_pkg::CAND_W'(r_c));

    // Compare against the destination entry, and saturate what is stored.
    assign dd_x     = mwr_pkg::CAND_W'($signed(dist_rdata));
    assign improves = !r_inf && (r_cand < dd_x);

    always_comb begin
        if (r_cand < mwr_pkg::CAND_LO) begin
            cand_sat = mwr_pkg::DIST_W'(mwr_pkg::CAND_LO);
        end else if (r_cand > mwr_pkg::CAND_HI) begin
            cand_sat = mwr_pkg::DIST_W'(mwr_pkg::CAND_HI);
        end else begin
            cand_sat = mwr_pkg::DIST_W'(r_cand);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwr_pkg::BF_IDLE: begin
                if (i_start) begin
                    n_state = (i_n == '0) ? mwr_pkg::BF_ESTART : mwr_pkg::BF_INIT;
                end
            end
            mwr_pkg::BF_INIT: begin
                if (r_vidx == i_n) begin
                    n_state = mwr_pkg::BF_ESTART;
                end
            end
            mwr_pkg::BF_ESTART: begin
                n_state = (i_edge_count == '0) ? mwr_pkg::BF_EEND : mwr_pkg::BF_EREAD;
            end
            mwr_pkg::BF_EREAD: n_state = mwr_pkg::BF_EWAIT;
            mwr_pkg::BF_EWAIT: begin
                if (e_in_range) begin
                    n_state = mwr_pkg::BF_DS;
                end else begin
                    n_state = last_edge ? mwr_pkg::BF_EEND : mwr_pkg::BF_EREAD;
                end
            end
            mwr_pkg::BF_DS: n_state = mwr_pkg::BF_DD;
            mwr_pkg::BF_DD: begin
                if (improves && r_check) begin
                    n_state = mwr_pkg::BF_DONE;
                end else begin
                    n_state = last_edge ? mwr_pkg::BF_EEND : mwr_pkg::BF_EREAD;
                end
            end
            mwr_pkg::BF_EEND: begin
                if (r_check) begin
                    n_state = mwr_pkg::BF_DONE;
                end else if (i_n == '0) begin
                    n_state = mwr_pkg::BF_RNDEND;
                end else begin
                    n_state = mwr_pkg::BF_VREAD;
                end
            end
            mwr_pkg::BF_VREAD: n_state = mwr_pkg::BF_VWAIT;
            mwr_pkg::BF_VWAIT: begin
                if (r_vidx == i_n) begin
                    n_state = mwr_pkg::BF_RNDEND;
                end else begin
                    n_state = mwr_pkg::BF_VREAD;
                end
            end
            mwr_pkg::BF_RNDEND: n_state = mwr_pkg::BF_ESTART;
            mwr_pkg::BF_DONE:   n_state = mwr_pkg::BF_IDLE;
            default:            n_state = mwr_pkg::BF_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = r_vidx;
        dist_wdata = mwr_pkg::DIST_INF;
        dist_raddr = r_dst;
        case (r_state)
            mwr_pkg::BF_INIT: begin
                dist_we = 1'b1;
            end
            mwr_pkg::BF_EWAIT: begin
                dist_raddr = VW'(e_src);
            end
            mwr_pkg::BF_DD: begin
                dist_we    = improves && !r_check;
                dist_waddr = r_dst;
                dist_wdata = cand_sat;
            end
            mwr_pkg::BF_VREAD: begin
                dist_raddr = r_vidx;
            end
            mwr_pkg::BF_VWAIT: begin
                dist_we    = $signed(dist_rdata) > $signed(mwr_pkg::DIST_ONE);
                dist_wdata = mwr_pkg::DIST_ONE;
            end
            default: begin
                dist_we = 1'b0;
            end
        endcase
    end

    assign o_edge_raddr     = r_eidx;
    assign o_status.done     = (r_state == mwr_pkg::BF_DONE);
    assign o_status.no_cycle = r_ok;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwr_pkg::BF_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters, phase and result flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eidx  <= '0;
            r_vidx  <= '0;
            r_round <= '0;
            r_check <= 1'b0;
            r_ok    <= 1'b1;
        end else begin
            case (r_state)
                mwr_pkg::BF_IDLE: begin
                    if (i_start) begin
                        r_vidx  <= VW'(1);
                        r_round <= '0;
                        r_check <= 1'b0;
                        r_ok    <= 1'b1;
                    end
                end
                mwr_pkg::BF_INIT:   r_vidx <= r_vidx + VW'(1);
                mwr_pkg::BF_ESTART: r_eidx <= '0;
                mwr_pkg::BF_EWAIT: begin
                    if (!e_in_range && !last_edge) begin
                        r_eidx <= r_eidx + EAW'(1);
                    end
                end
                mwr_pkg::BF_DD: begin
                    if (improves && r_check) begin
                        r_ok <= 1'b0;
                    end else if (!last_edge) begin
                        r_eidx <= r_eidx + EAW'(1);
                    end
                end
                mwr_pkg::BF_EEND:  r_vidx <= VW'(1);
                mwr_pkg::BF_VWAIT: r_vidx <= r_vidx + VW'(1);
                mwr_pkg::BF_RNDEND: begin
                    if (r_round == i_n) begin
                        r_check <= 1'b1;
                    end else begin
                        r_round <= r_round + VW'(1);
                    end
                end
                default: begin
                    r_ok <= r_ok;
                end
            endcase
        end
    end

    // Datapath registers for the edge under work.
    always_ff @(posedge i_clk) begin
        if (r_state == mwr_pkg::BF_IDLE && i_start) begin
            r_c <= i_c;
        end
        if (r_state == mwr_pkg::BF_EWAIT) begin
            r_dst <= VW'(e_dst);
            r_wt  <= e_wt;
        end
        if (r_state == mwr_pkg::BF_DS) begin
            r_cand <= cand_now;
            r_inf  <= (dist_rdata == mwr_pkg::DIST_INF);
        end
    end

    mwr_ram #(
        .WIDTH (mwr_pkg::DIST_W),
        .DEPTH (MAX_VERTICES + 1)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    // The virtual source entry is never written.
    a_no_source_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_we |-> (dist_waddr != '0))
        else $error("distance write to the virtual source entry");

    // A negative cycle is only reported from the check pass.
    a_fail_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mwr_pkg::BF_DONE && !r_ok) |-> r_check)
        else $error("negative cycle reported outside the check pass");

    // The round counter stays within the vertex count.
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mwr_pkg::BF_IDLE) |-> (32'(r_round) <= 32'(i_n)))
        else $error("relaxation round beyond vertex count");

endmodule

@@ rtl/max_uniform_weight_reduction.sv @@
// Top level: edge loading, min/max tracking, binary search; uses mwr_pkg, mwr_ram, mwr_bf.
// Search: a last-edge request starts a binary search that tests T values (about log2 of the
//   weight range), each by one Bellman-Ford test over the n vertices and E stored edges.
// Throughput: non-last edges are taken one per cycle while idle; one graph at a time.
// Reset: synchronous active-low; clears edge count, bounds and flags; no memory clearing.
module max_uniform_weight_reduction #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [6:0]  i_in_edge_source,
    input  logic [6:0]  i_in_edge_dest,
    input  logic [15:0] i_in_edge_weight,
    input  logic        i_in_last_edge,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_max_reduction,
    output logic        o_out_edge_overflow
);

    localparam int CW  = WEIGHT_BITS + 1;
    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = 14 + WEIGHT_BITS;

    mwr_pkg::t_top_state r_state, n_state;

    logic [6:0]             r_vertex_count;
    logic [ECW-1:0]         r_count;
    logic [WEIGHT_BITS-1:0] r_min;
    logic [WEIGHT_BITS-1:0] r_max;
    logic                   r_ovf;
    logic [CW-1:0]          r_lb;
    logic [CW-1:0]          r_ub;
    logic [CW-1:0]          r_mid;
    logic                   r_out_valid;
    logic [15:0]            r_out_red;
    logic                   r_out_ovf;

    logic                   accept;
    logic                   store_ok;
    logic [WEIGHT_BITS-1:0] in_wt;
    logic [VW-1:0]          n_eff;
    logic                   search_more;
    logic [CW-1:0]          mid;
    logic                   bf_start;
    logic [EAW-1:0]         edge_raddr;
    logic [EW-1:0]          edge_rdata;
    mwr_pkg::t_bf_status    bf_status;

    assign accept   = i_in_valid && !o_in_stall;
    assign store_ok = 32'(r_count) < 32'(MAX_EDGES);
    assign in_wt    = WEIGHT_BITS'(i_in_edge_weight);

    // Effective vertex count, limited to the capacity.
    always_comb begin
        if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            n_eff = VW'(MAX_VERTICES);
        end else begin
            n_eff = VW'(r_vertex_count);
        end
    end

    // Search interval and midpoint.
    assign search_more = ({1'b0, r_lb} + (CW + 1)'(1)) < {1'b0, r_ub};
    assign mid         = CW'(({1'b0, r_lb} + {1'b0, r_ub}) >> 1);

    // Requests are held while a search runs, and a new last edge waits for the
    // previous result to be taken.
    assign o_in_stall = (r_state != mwr_pkg::T_IDLE) || (i_in_last_edge && r_out_valid);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwr_pkg::T_IDLE: begin
                if (accept && i_in_last_edge) begin
                    n_state = mwr_pkg::T_BOUNDS;
                end
            end
            mwr_pkg::T_BOUNDS: n_state = mwr_pkg::T_DECIDE;
            mwr_pkg::T_DECIDE: begin
                n_state = search_more ? mwr_pkg::T_WAIT : mwr_pkg::T_IDLE;
            end
            mwr_pkg::T_WAIT: begin
                if (bf_status.done) begin
                    n_state = mwr_pkg::T_DECIDE;
                end
            end
            default: n_state = mwr_pkg::T_IDLE;
        endcase
    end

    // FSM outputs.
    always_comb begin
        case (r_state)
            mwr_pkg::T_DECIDE: bf_start = search_more;
            default:           bf_start = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= mwr_pkg::T_IDLE;
            r_vertex_count <= 7'd1;
            r_count        <= '0;
            r_min          <= '1;
            r_max          <= '0;
            r_ovf          <= 1'b0;
            r_lb           <= '0;
            r_ub           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Edge loading and weight range.
            if (accept) begin
                if (store_ok) begin
                    r_count <= r_count + ECW'(1);
                    if (in_wt < r_min) begin
                        r_min <= in_wt;
                    end
                    if (in_wt > r_max) begin
                        r_max <= in_wt;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            case (r_state)
                mwr_pkg::T_BOUNDS: begin
                    r_lb <= CW'(r_min);
                    r_ub <= CW'(r_max) + CW'(1);
                end
                mwr_pkg::T_DECIDE: begin
                    // Search finished: deliver and clear for the next graph.
                    if (!search_more) begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_min       <= '1;
                        r_max       <= '0;
                        r_ovf       <= 1'b0;
                    end
                end
                mwr_pkg::T_WAIT: begin
                    if (bf_status.done) begin
                        if (bf_status.no_cycle) begin
                            r_lb <= r_mid;
                        end else begin
                            r_ub <= r_mid;
                        end
                    end
                end
                default: begin
                    r_lb <= r_lb;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == mwr_pkg::T_DECIDE) begin
            r_mid <= mid;
            if (!search_more) begin
                r_out_red <= 16'(r_lb);
                r_out_ovf <= r_ovf;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_max_reduction = r_out_red;
    assign o_out_edge_overflow = r_out_ovf;

    mwr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (accept && store_ok),
        .i_waddr (r_count[EAW-1:0]),
        .i_wdata ({i_in_edge_source, i_in_edge_dest, in_wt}),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    mwr_bf #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_bf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (bf_start),
        .i_c          (mid),
        .i_n          (n_eff),
        .i_edge_count (r_count),
        .o_edge_raddr (edge_raddr),
        .i_edge_rdata (edge_rdata),
        .o_status     (bf_status)
    );

    // Requests are taken only while no search runs.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (r_state == mwr_pkg::T_IDLE))
        else $error("request accepted during a search");

    // A test result arrives only while the search waits for one.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bf_status.done |-> (r_state == mwr_pkg::T_WAIT))
        else $error("test result outside the wait state");

    // The tested value lies strictly inside the search interval.
    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mwr_pkg::T_WAIT) |-> ((r_lb < r_mid) && (r_mid < r_ub)))
        else $error("midpoint outside the search interval");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for max_uniform_weight_reduction: loads graphs and compares
// each reduction result against an in-bench Bellman-Ford search. Depends only on the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 64;
    localparam int NE = 1024;
    localparam longint INF = 64'sd2147483647;
    localparam int WATCH_LIMIT = 3000000;
    localparam int SETTLE = 20;

    typedef enum int { IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE } t_idle_mode;

    typedef struct {
        logic [15:0] reduction;
        logic        overflow;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [6:0]  i_in_edge_source;
    logic [6:0]  i_in_edge_dest;
    logic [15:0] i_in_edge_weight;
    logic        i_in_last_edge;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_out_max_reduction;
    logic        o_out_edge_overflow;

    max_uniform_weight_reduction dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_edge_source(i_in_edge_source), .i_in_edge_dest(i_in_edge_dest),
        .i_in_edge_weight(i_in_edge_weight), .i_in_last_edge(i_in_last_edge),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_max_reduction(o_out_max_reduction),
        .o_out_edge_overflow(o_out_edge_overflow)
    );

    // Mirror of the block's graph store and search bounds.
    logic [6:0]  graph_src [NE];
    logic [6:0]  graph_dst [NE];
    logic [15:0] graph_wt  [NE];
    int          graph_edges;
    logic [15:0] weight_lo;
    logic [15:0] weight_hi;
    logic        graph_dropped;
    logic [6:0]  vertex_reg;

    t_result     pending_results[$];
    t_idle_mode  idle_mode;
    int          hold_left;
    int          mismatches;
    int          results_seen;
    int          graphs_sent;
    int          quiet_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Saturate a candidate distance to the signed 32-bit range, one below infinity.
    function automatic longint clamp_distance(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > INF - 1) return INF - 1;
        return v;
    endfunction

    // True if every weight reduced by c leaves the graph free of negative cycles.
    function automatic bit cycle_free(longint c, int n);
        longint path_len [NV+1];
        longint cand;
        int s;
        int d;
        path_len[0] = 0;
        for (int v = 1; v <= n; v++) path_len[v] = INF;
        for (int r = 0; r < n + 1; r++) begin
            for (int e = 0; e < graph_edges; e++) begin
                s = int'(graph_src[e]);
                d = int'(graph_dst[e]);
                if (s < 1 || s > n || d < 1 || d > n) continue;
                if (path_len[s] == INF) continue;
                cand = path_len[s] + longint'(graph_wt[e]) - c;
                if (cand < path_len[d]) path_len[d] = clamp_distance(cand);
            end
            for (int v = 1; v <= n; v++) begin
                if (path_len[0] + 1 < path_len[v]) path_len[v] = path_len[0] + 1;
            end
        end
        for (int e = 0; e < graph_edges; e++) begin
            s = int'(graph_src[e]);
            d = int'(graph_dst[e]);
            if (s < 1 || s > n || d < 1 || d > n) continue;
            if (path_len[s] == INF) continue;
            if (path_len[s] + longint'(graph_wt[e]) - c < path_len[d]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_graph();
        graph_edges = 0;
        weight_lo = 16'hFFFF;
        weight_hi = 16'h0000;
        graph_dropped = 1'b0;
    endfunction

    // Update the mirror with one accepted edge and predict the reduction on the last one.
    function automatic void track_edge(logic [6:0] s, logic [6:0] d, logic [15:0] w,
                                       logic last);
        longint lo;
        longint hi;
        longint mid;
        int n;
        t_result res;
        if (graph_edges < NE) begin
            graph_src[graph_edges] = s;
            graph_dst[graph_edges] = d;
            graph_wt[graph_edges] = w;
            graph_edges++;
            if (w < weight_lo) weight_lo = w;
            if (w > weight_hi) weight_hi = w;
        end else begin
            graph_dropped = 1'b1;
        end
        if (!last) return;
        n = (vertex_reg > NV) ? NV : int'(vertex_reg);
        lo = longint'(weight_lo);
        hi = longint'(weight_hi) + 1;
        while (lo + 1 < hi) begin
            mid = lo + (hi - lo) / 2;
            if (cycle_free(mid, n)) lo = mid;
            else hi = mid;
        end
        res.reduction = lo[15:0];
        res.overflow = graph_dropped;
        pending_results.insert(pending_results.size(), res);
        clear_graph();
    endfunction

    // Offer one edge request after idle cycles drawn one at a time, and wait until it is taken.
    task automatic send_edge(logic [6:0] s, logic [6:0] d, logic [15:0] w, logic last);
        int pct;
        pct = 0;
        if (idle_mode == IDLE_SEND_LIGHT) pct = 22;
        if (idle_mode == IDLE_RECV_LIGHT) pct = 50;
        @(negedge i_clk);
        while ($urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_edge_source <= s;
        i_in_edge_dest <= d;
        i_in_edge_weight <= w;
        i_in_last_edge <= last;
        do @(posedge i_clk); while (o_in_stall);
        track_edge(s, d, w, last);
        if (last) graphs_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back, then let the block settle.
    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [6:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        vertex_reg = value;
    endtask

    // One random graph of a few edges, mostly inside the vertex range.
    task automatic send_random_graph(int n_edges, int n);
        logic [15:0] base;
        logic [15:0] w;
        int spread;
        logic [6:0] s;
        logic [6:0] d;
        base = 16'($urandom_range(65535));
        spread = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 300);
        for (int e = 0; e < n_edges; e++) begin
            if (spread == 65535) w = 16'($urandom_range(65535));
            else w = (int'(base) + $urandom_range(spread) > 65535) ?
                     16'(16'hFFFF - $urandom_range(spread)) : 16'(base + $urandom_range(spread));
            if ($urandom_range(9) == 0 || n == 0) begin
                s = 7'($urandom_range(127));
                d = 7'($urandom_range(127));
            end else begin
                s = 7'($urandom_range(1, (n > NV) ? NV : n));
                d = 7'($urandom_range(1, (n > NV) ? NV : n));
            end
            send_edge(s, d, w, e == n_edges - 1);
        end
    endtask

    // Weight and vertex extremes, self loops and vertices outside the range.
    task automatic test_extremes();
        write_vertex_count(7'd1);
        send_edge(7'd1, 7'd1, 16'd0, 1'b1);
        send_edge(7'd1, 7'd1, 16'hFFFF, 1'b1);
        send_edge(7'd1, 7'd1, 16'd0, 1'b0);
        send_edge(7'd1, 7'd1, 16'hFFFF, 1'b1);
        write_vertex_count(7'd3);
        send_edge(7'd1, 7'd2, 16'd10, 1'b0);
        send_edge(7'd2, 7'd3, 16'd20, 1'b0);
        send_edge(7'd3, 7'd1, 16'd30, 1'b0);
        send_edge(7'd0, 7'd2, 16'd1, 1'b0);
        send_edge(7'd2, 7'd127, 16'd2, 1'b1);
        write_vertex_count(7'd0);
        send_edge(7'd1, 7'd1, 16'd7, 1'b0);
        send_edge(7'd1, 7'd1, 16'd900, 1'b1);
        write_vertex_count(7'd127);
        send_edge(7'd64, 7'd1, 16'd100, 1'b0);
        send_edge(7'd1, 7'd64, 16'd50, 1'b0);
        send_edge(7'd65, 7'd64, 16'd3, 1'b1);
        write_vertex_count(7'd64);
        send_edge(7'd64, 7'd64, 16'h8000, 1'b0);
        send_edge(7'd63, 7'd64, 16'h7FFF, 1'b1);
    endtask

    // Fill the edge store past its capacity; the last edge is dropped yet still starts the search.
    task automatic test_store_full();
        write_vertex_count(7'd1);
        for (int e = 0; e < NE + 2; e++) begin
            send_edge(7'd1, 7'd1, 16'd42, e == NE + 1);
        end
        send_edge(7'd1, 7'd1, 16'd5, 1'b1);
    endtask

    // Random graphs under the current idle mode, with occasional vertex count changes.
    task automatic test_random(int item_budget);
        int sent;
        int k;
        int big_left;
        sent = 0;
        big_left = 1;
        while (sent < item_budget) begin
            if ($urandom_range(3) == 0) begin
                k = $urandom_range(9);
                if (k == 0) write_vertex_count(7'd0);
                else if (k == 1 && big_left > 0) begin
                    write_vertex_count($urandom_range(1) ? 7'd64 : 7'd127);
                    big_left--;
                end else write_vertex_count(7'($urandom_range(1, 8)));
            end
            k = $urandom_range(1, 6);
            send_random_graph(k, int'(vertex_reg));
            sent += k;
        end
        write_vertex_count(7'($urandom_range(1, 8)));
    endtask

    // Hold the result side for a long stretch while edges keep coming, drain, then send one more graph.
    task automatic test_backpressure();
        write_vertex_count(7'd4);
        hold_left = 400;
        for (int g = 0; g < 4; g++) send_random_graph(3, 4);
        drain();
        send_random_graph(5, 4);
    endtask

    // Receiver stall pattern and the long hold.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (idle_mode)
                IDLE_SEND_LIGHT: i_out_stall <= ($urandom_range(99) < 50);
                IDLE_RECV_LIGHT: i_out_stall <= ($urandom_range(99) < 22);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: reduction %0d overflow %0b",
                              o_out_max_reduction, o_out_edge_overflow);
            end else begin
                want = pending_results.pop_front();
                if (o_out_max_reduction !== want.reduction ||
                    o_out_edge_overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected reduction %0d overflow %0b, got %0d %0b",
                                 want.reduction, want.overflow,
                                 o_out_max_reduction, o_out_edge_overflow);
                end
            end
        end
    end

    // Watchdog over cycles in which neither side accepts a request and no configuration is written.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_edge_source = '0;
        i_in_edge_dest = '0;
        i_in_edge_weight = '0;
        i_in_last_edge = 1'b0;
        i_out_stall = 1'b0;
        idle_mode = IDLE_NONE;
        hold_left = 0;
        mismatches = 0;
        results_seen = 0;
        graphs_sent = 0;
        quiet_cycles = 0;
        vertex_reg = 7'd1;
        clear_graph();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_store_full();
        idle_mode = IDLE_SEND_LIGHT;
        test_random(190);
        idle_mode = IDLE_RECV_LIGHT;
        test_random(190);
        idle_mode = IDLE_NONE;
        test_random(190);
        test_backpressure();
        drain();

        $display("covered %0d graphs and %0d results: weight and vertex extremes,", graphs_sent,
                 results_seen);
        $display("store overflow, random graphs under three idle patterns and a long hold");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/mwr_pkg.sv
rtl/mwr_ram.sv
rtl/mwr_bf.sv
rtl/max_uniform_weight_reduction.sv
verif/tb_top.sv
